/* design/nhht_pkg.sv */
// ----------------------------------------------------------------------------
// nhht_pkg
// Shared types and constants of the numbered handle hash table.
// ----------------------------------------------------------------------------
package nhht_pkg;

  // Slot count; must be a power of two so that slot indexes wrap on their own.
  localparam int unsigned SLOTS    = 64;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = SLOT_W + 1;
  localparam int unsigned IN_USE_W = 7;

  // Install is refused while the occupied count is above this.
  localparam int unsigned OCC_HALF   = SLOTS / 2;
  // Highest occupied count the table can ever report.
  localparam int unsigned MAX_IN_USE = OCC_HALF + 1;

  localparam logic [31:0] FIB_MULT = 32'd2654435761;

  // Opcodes
  localparam logic [1:0] OP_INSTALL = 2'd0;
  localparam logic [1:0] OP_FIND    = 2'd1;
  localparam logic [1:0] OP_ERASE   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         assigned_key;
    logic [31:0]         found_payload;
    logic [IN_USE_W-1:0] in_use;
    logic [31:0]         next_ticket;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
  } entry_t;

endpackage

/* design/numbered_handle_hash_table.sv */
// Steps: install hashes, then probes down to an empty slot; find reads, then
//   compares each slot; erase then walks the run below the hole to compact it.
//   Refused install and unused opcode answer in the cycle after the start beat.
// Throughput: one item at a time; busy_o stays high until the result beat.
//   The single-port slot memory (one read or write per cycle) sets the pace.
// Reset: valid bits, ticket and occupied counters clear at once; slot contents
//   are left as they are and never read before being written.
// ----------------------------------------------------------------------------
// numbered_handle_hash_table
// Open-addressed table of numbered handles with downward linear probing and
// backward-shift compaction on erase. Keys and payloads live in one
// synchronous memory; slot valid bits live in flip-flops.
// ----------------------------------------------------------------------------
module numbered_handle_hash_table import nhht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;  // wait for a start beat
  localparam logic [2:0] S_HOME    = 3'd1;  // hash key into home slot
  localparam logic [2:0] S_INS     = 3'd2;  // walk down to first empty slot
  localparam logic [2:0] S_LOOK    = 3'd3;  // check valid, read slot
  localparam logic [2:0] S_CMP     = 3'd4;  // compare stored key
  localparam logic [2:0] S_SH_LOOK = 3'd5;  // compaction: step down, read slot
  localparam logic [2:0] S_SH_MUL  = 3'd6;  // compaction: hash stored key
  localparam logic [2:0] S_SH_CMP  = 3'd7;  // compaction: move into hole or skip

  logic [2:0]          state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [31:0]         key_q, key_d;
  logic [31:0]         pay_q, pay_d;
  slot_t               p_q, p_d;
  slot_t               hole_q, hole_d;
  slot_t               h_q, h_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [31:0]         fpay_q, fpay_d;
  logic [31:0]         ticket_q, ticket_d;
  logic [IN_USE_W-1:0] occ_q, occ_d;
  logic [SLOTS-1:0]    valid_q, valid_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;

  // Slot memory: one access per cycle, registered read data
  entry_t mem [SLOTS];
  entry_t rd_q;
  logic   mem_we, mem_re;
  slot_t  mem_wa, mem_ra;
  entry_t mem_wd;

  // Shared hash multiplier: low 32 bits of key * golden ratio constant
  logic [31:0] mul_a, mul_p;
  slot_t       mul_home;
  slot_t       p_dn;
  slot_t       dist_hole, dist_p;

  // Result assembly
  logic        fin;
  logic [1:0]  fin_status;
  logic [31:0] fin_akey, fin_fpay;

  assign mul_a    = (state_q == S_SH_MUL) ? rd_q.key : key_q;
  assign mul_p    = mul_a * FIB_MULT;
  assign mul_home = mul_p[31 -: SLOT_W];

  // Probe direction is downward; slot index wraps naturally at a power of two
  assign p_dn      = p_q - slot_t'(1);
  assign dist_hole = h_q - hole_q;
  assign dist_p    = h_q - p_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    pay_d      = pay_q;
    p_d        = p_q;
    hole_d     = hole_q;
    h_d        = h_q;
    cnt_d      = cnt_q;
    fpay_d     = fpay_q;
    ticket_d   = ticket_q;
    occ_d      = occ_q;
    valid_d    = valid_q;
    mem_we     = 1'b0;
    mem_wa     = p_q;
    mem_wd     = '{key: key_q, payload: pay_q};
    mem_re     = 1'b0;
    mem_ra     = p_q;
    fin        = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_akey   = key_q;
    fin_fpay   = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = req_i.opcode;
          key_d = req_i.key;
          pay_d = req_i.payload;
          case (req_i.opcode)
            OP_INSTALL: begin
              // The new entry's key is the current ticket
              key_d = ticket_q;
              if (occ_q > IN_USE_W'(OCC_HALF)) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
                fin_akey   = ticket_q;
              end else begin
                state_d = S_HOME;
              end
            end
            OP_FIND, OP_ERASE: begin
              state_d = S_HOME;
            end
            default: begin
              // Unused opcode answers like a failed find
              fin      = 1'b1;
              fin_akey = req_i.key;
            end
          endcase
        end
      end

      S_HOME: begin
        p_d     = mul_home;
        cnt_d   = '0;
        state_d = (op_q == OP_INSTALL) ? S_INS : S_LOOK;
      end

      S_INS: begin
        if (!valid_q[p_q]) begin
          mem_we      = 1'b1;
          mem_wa      = p_q;
          valid_d[p_q] = 1'b1;
          ticket_d    = ticket_q + 32'd1;
          occ_d       = occ_q + IN_USE_W'(1);
          fin         = 1'b1;
          fin_status  = ST_OK;
        end else if (cnt_q == CNT_W'(SLOTS - 1)) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
        end else begin
          p_d   = p_dn;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      S_LOOK: begin
        if (!valid_q[p_q]) begin
          // Empty slot ends the run: key absent
          fin = 1'b1;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = p_q;
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        if (rd_q.key == key_q) begin
          if (op_q == OP_ERASE) begin
            // Open the hole and start compaction below it
            valid_d[p_q] = 1'b0;
            hole_d       = p_q;
            fpay_d       = rd_q.payload;
            if (occ_q != '0) begin
              occ_d = occ_q - IN_USE_W'(1);
            end
            cnt_d   = '0;
            state_d = S_SH_LOOK;
          end else begin
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_fpay   = rd_q.payload;
          end
        end else if (cnt_q == CNT_W'(SLOTS - 1)) begin
          fin = 1'b1;
        end else begin
          p_d     = p_dn;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_LOOK;
        end
      end

      S_SH_LOOK: begin
        if (!valid_q[p_dn]) begin
          fin        = 1'b1;
          fin_status = ST_OK;
          fin_fpay   = fpay_q;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = p_dn;
          p_d     = p_dn;
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = S_SH_MUL;
        end
      end

      S_SH_MUL: begin
        h_d     = mul_home;
        state_d = S_SH_CMP;
      end

      S_SH_CMP: begin
        // Move the entry up if the hole lies nearer its home than it does
        if (dist_hole < dist_p) begin
          mem_we          = 1'b1;
          mem_wa          = hole_q;
          mem_wd          = rd_q;
          valid_d[hole_q] = 1'b1;
          valid_d[p_q]    = 1'b0;
          hole_d          = p_q;
        end
        if (cnt_q == CNT_W'(SLOTS)) begin
          fin        = 1'b1;
          fin_status = ST_OK;
          fin_fpay   = fpay_q;
        end else begin
          state_d = S_SH_LOOK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = S_IDLE;
    end

    done_d = fin;
    rsp_d  = '{status:        fin_status,
               assigned_key:  fin_akey,
               found_payload: fin_fpay,
               in_use:        occ_d,
               next_ticket:   ticket_d};
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      ticket_q <= '0;
      occ_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      ticket_q <= ticket_d;
      occ_q    <= occ_d;
      done_q   <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    p_q    <= p_d;
    hole_q <= hole_d;
    h_q    <= h_d;
    cnt_q  <= cnt_d;
    fpay_q <= fpay_d;
    rsp_q  <= rsp_d;
  end

  // Slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* design/nhht_checker.sv */
// ----------------------------------------------------------------------------
// nhht_checker
// Port-level checks of the numbered handle hash table, bound to the top.
// ----------------------------------------------------------------------------
module nhht_checker import nhht_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  // An accepted beat either keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted beat neither started work nor answered");

  // A result beat leaves the block free for the next item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while still busy");

  // Occupancy never passes the half-full limit plus one
  a_in_use_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.in_use <= IN_USE_W'(MAX_IN_USE)))
    else $error("in_use above limit");

  // A refused install reports the ticket it did not consume
  a_full_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.assigned_key == rsp_o.next_ticket))
    else $error("refused install moved the ticket");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_NOT_FOUND ||
                rsp_o.status == ST_FULL))
    else $error("undefined status code");

endmodule

bind numbered_handle_hash_table nhht_checker u_nhht_checker (.*);
